### rtl/msm_pkg.sv
`default_nettype none
package msm_pkg;

	// command codes carried in tuser
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_PLAY     = 3'd2,
		OP_STOP     = 3'd3,
		OP_VOLUME   = 3'd4,
		OP_STOP_ALL = 3'd5
	} op_t;

	// one command beat as queued between front and back
	typedef struct packed {
		op_t         opcode;
		logic [1:0]  voice;
		logic [15:0] address;
		logic [7:0]  sample_byte;
		logic [15:0] length;
		logic [15:0] loop_start;
		logic [15:0] loop_length;
		logic [15:0] frequency;
		logic [6:0]  volume;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_VOICE,
		ST_ADDR2,
		ST_MUL,
		ST_SCALE,
		ST_ACC,
		ST_OUT
	} state_t;

	localparam int STEP_W = 24;
	localparam int RATE_W = 16;

endpackage
`default_nettype wire

### rtl/multichannel_sample_mixer.sv
`default_nettype none
// Four-voice wavetable mixer with linear interpolation.
// Commands enter on the s_axis channel: tuser carries opcode and voice, tdata
// the remaining fields. Unknown opcodes are dropped at the input.
// A two-beat command queue sits in front of the sequencer, so commands are
// taken while the sequencer works or while an output beat waits.
// Only a tick produces a beat on m_axis: the mixed mono sample.
// Sequencer: write, stop, stop-all and set-volume are executed from idle;
// play waits for the bit-serial step divider (one quotient bit per cycle);
// a tick visits each voice in turn: an idle voice, or one whose one-shot
// ends, in a single state, a playing voice through the voice, second-address,
// multiply, scale and accumulate states, set by the single sample memory port.
// cfg_wr_en/cfg_wr_data set the output rate, used by later play commands.
// Reset clears all voices and the queue and restores the rate to 22050.
// Sample memory is not cleared; SAMPLE_MEM_DEPTH must be a power of two.
// When m_axis stalls, one result is held and the next tick waits at its end;
// commands keep queuing until the queue is full.
module multichannel_sample_mixer #(
	parameter int VOICES           = 4,
	parameter int SAMPLE_MEM_DEPTH = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// address, sample_byte, length, loop_start, loop_length, frequency, volume
	input  wire logic [95:0] s_axis_tdata,
	// opcode, voice
	input  wire logic [4:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// mixed_sample
	output logic      [15:0] m_axis_tdata,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	msm_pkg::cmd_t in_cmd;
	msm_pkg::cmd_t q_cmd;
	logic          q_valid;
	logic          q_pop;
	logic [15:0]   rate_q;

	// unpack the command beat
	always_comb begin
		in_cmd.opcode      = msm_pkg::op_t'(s_axis_tuser[2:0]);
		in_cmd.voice       = s_axis_tuser[4:3];
		in_cmd.address     = s_axis_tdata[15:0];
		in_cmd.sample_byte = s_axis_tdata[23:16];
		in_cmd.length      = s_axis_tdata[39:24];
		in_cmd.loop_start  = s_axis_tdata[55:40];
		in_cmd.loop_length = s_axis_tdata[71:56];
		in_cmd.frequency   = s_axis_tdata[87:72];
		in_cmd.volume      = s_axis_tdata[94:88];
	end

	// output rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 16'd22050;
		end else if (cfg_wr_en) begin
			rate_q <= cfg_wr_data;
		end
	end

	msm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (in_cmd),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	msm_engine #(
		.VOICES           (VOICES),
		.SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.rate       (rate_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (m_axis_tdata)
	);

endmodule
`default_nettype wire

### rtl/msm_ram.sv
`default_nettype none
module msm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/msm_front.sv
`default_nettype none
// Accepts command beats, drops unknown opcodes, queues the rest (2 deep).
module msm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire msm_pkg::cmd_t in_cmd,
	output logic               q_valid,
	output msm_pkg::cmd_t      q_cmd,
	input  wire logic          q_pop
);

	msm_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          known;
	logic          push;

	// opcodes above stop-all do nothing
	assign known    = in_cmd.opcode <= msm_pkg::OP_STOP_ALL;
	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready && known;
	assign q_valid  = cnt_q != 2'd0;
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule
`default_nettype wire

### rtl/msm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Zero divisor gives all ones.
module msm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [msm_pkg::STEP_W-1:0]   dividend,
	input  wire logic [msm_pkg::RATE_W-1:0]   divisor,
	output logic                              done,
	output logic      [msm_pkg::STEP_W-1:0]   quotient
);

	logic [msm_pkg::STEP_W-1:0] quo_q;
	logic [msm_pkg::RATE_W-1:0] rem_q;
	logic [msm_pkg::RATE_W-1:0] div_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [msm_pkg::RATE_W:0]   trial;
	logic                       fits;
	logic [msm_pkg::RATE_W:0]   diff;

	assign trial    = {rem_q, quo_q[msm_pkg::STEP_W-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[msm_pkg::RATE_W-1:0] : trial[msm_pkg::RATE_W-1:0];
			quo_q <= {quo_q[msm_pkg::STEP_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(msm_pkg::STEP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/msm_engine.sv
`default_nettype none
// Back end: executes queued commands, sequences voices through one RAM port.
module msm_engine #(
	parameter int VOICES           = 4,
	parameter int SAMPLE_MEM_DEPTH = 65536
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire msm_pkg::cmd_t              q_cmd,
	output logic                            q_pop,
	input  wire logic [msm_pkg::RATE_W-1:0] rate,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [15:0]                out_sample
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = $clog2(SAMPLE_MEM_DEPTH);

	msm_pkg::state_t state_q, state_d;
	msm_pkg::cmd_t   cmd_q;

	// per-voice state
	logic                       active_q [VOICES];
	logic [6:0]                 vol_q    [VOICES];
	logic [msm_pkg::STEP_W-1:0] pos_q    [VOICES];
	logic [msm_pkg::STEP_W-1:0] step_q   [VOICES];
	logic [15:0]                base_q   [VOICES];
	logic [15:0]                len_q    [VOICES];
	logic [15:0]                ls_q     [VOICES];
	logic [15:0]                ll_q     [VOICES];

	logic [VW-1:0]        idx_q;
	logic [AW-1:0]        a2_q;
	logic [7:0]           frac_q;
	logic signed [7:0]    b1_q;
	logic signed [16:0]   s_s1;
	logic signed [16:0]   prod_s2;
	logic signed [15:0]   sum_q;
	logic                 out_valid_q;
	logic [15:0]          out_q;

	// current voice view
	logic [msm_pkg::STEP_W-1:0] cur_pos;
	logic [15:0]                p1;
	logic [15:0]                p2;
	logic [16:0]                p1_inc;
	logic                       looped;
	logic                       loop_hit;
	logic                       oneshot_end;
	logic [msm_pkg::STEP_W-1:0] next_pos;
	logic [15:0]                a1;
	logic [15:0]                a2;
	logic                       last_voice;

	// command voice decode
	logic          vok;
	logic [VW-1:0] cvi;
	logic [VW-1:0] qvi;
	logic          q_vok;

	// RAM and divider hookups
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          div_start;
	logic          div_done;
	logic [msm_pkg::STEP_W-1:0] div_quo;

	logic signed [8:0]  b_floor;
	logic signed [16:0] prod_adj;
	logic signed [10:0] contrib;

	assign cur_pos     = pos_q[idx_q];
	assign p1          = cur_pos[23:8];
	assign p1_inc      = {1'b0, p1} + 17'd1;
	assign looped      = ll_q[idx_q] != 16'd0;
	assign loop_hit    = p1_inc >= ({1'b0, ls_q[idx_q]} + {1'b0, ll_q[idx_q]});
	assign oneshot_end = p1_inc >= {1'b0, len_q[idx_q]};
	assign p2          = (looped && loop_hit) ? ls_q[idx_q] : p1 + 16'd1;
	assign next_pos    = (looped && loop_hit) ? {ls_q[idx_q], 8'h00}
	                                          : cur_pos + step_q[idx_q];
	assign a1          = base_q[idx_q] + p1;
	assign a2          = base_q[idx_q] + p2;
	assign last_voice  = idx_q == VW'(VOICES - 1);

	assign cvi   = VW'(cmd_q.voice);
	assign vok   = 32'(cmd_q.voice) < VOICES;
	assign qvi   = VW'(q_cmd.voice);
	assign q_vok = 32'(q_cmd.voice) < VOICES;

	// floor of s/256, then volume/64 truncated toward zero
	assign b_floor  = 9'(s_s1 >>> 8);
	assign prod_adj = prod_s2 + (prod_s2[16] ? 17'sd63 : 17'sd0);
	assign contrib  = 11'(prod_adj >>> 6);

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

	msm_ram #(
		.WIDTH(8),
		.DEPTH(SAMPLE_MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_cmd.address[AW-1:0]),
		.wdata (q_cmd.sample_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	msm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({q_cmd.frequency, 8'h00}),
		.divisor  (rate),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = a1[AW-1:0];
		div_start = 1'b0;
		unique case (state_q)
			msm_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_cmd.opcode)
						msm_pkg::OP_TICK:  state_d = msm_pkg::ST_VOICE;
						msm_pkg::OP_WRITE: ram_we = 1'b1;
						msm_pkg::OP_PLAY: begin
							if (q_vok) begin
								div_start = 1'b1;
								state_d   = msm_pkg::ST_DIV;
							end
						end
						default: state_d = msm_pkg::ST_IDLE;
					endcase
				end
			end
			msm_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = msm_pkg::ST_IDLE;
				end
			end
			msm_pkg::ST_VOICE: begin
				if (active_q[idx_q] && (looped || !oneshot_end)) begin
					state_d = msm_pkg::ST_ADDR2;
				end else if (last_voice) begin
					state_d = msm_pkg::ST_OUT;
				end
			end
			msm_pkg::ST_ADDR2: begin
				ram_raddr = a2_q;
				state_d   = msm_pkg::ST_MUL;
			end
			msm_pkg::ST_MUL:   state_d = msm_pkg::ST_SCALE;
			msm_pkg::ST_SCALE: state_d = msm_pkg::ST_ACC;
			msm_pkg::ST_ACC: begin
				state_d = last_voice ? msm_pkg::ST_OUT : msm_pkg::ST_VOICE;
			end
			msm_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = msm_pkg::ST_IDLE;
				end
			end
			default: state_d = msm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath pipeline registers
	always_ff @(posedge clk) begin
		if (state_q == msm_pkg::ST_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
		if (state_q == msm_pkg::ST_VOICE) begin
			a2_q   <= a2[AW-1:0];
			frac_q <= cur_pos[7:0];
		end
		if (state_q == msm_pkg::ST_ADDR2) begin
			b1_q <= signed'(ram_rdata);
		end
		if (state_q == msm_pkg::ST_MUL) begin
			s_s1 <= 17'(b1_q * signed'({1'b0, 8'hFF - frac_q}))
			      + 17'(signed'(ram_rdata) * signed'({1'b0, frac_q}));
		end
		if (state_q == msm_pkg::ST_SCALE) begin
			prod_s2 <= 17'(b_floor * signed'({1'b0, vol_q[idx_q]}));
		end
	end

	// voice table and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				active_q[i] <= 1'b0;
				vol_q[i]    <= '0;
				pos_q[i]    <= '0;
				step_q[i]   <= '0;
				base_q[i]   <= '0;
				len_q[i]    <= '0;
				ls_q[i]     <= '0;
				ll_q[i]     <= '0;
			end
			idx_q       <= '0;
			sum_q       <= '0;
		end else begin
			unique case (state_q)
				msm_pkg::ST_IDLE: begin
					if (q_valid) begin
						idx_q <= '0;
						sum_q <= '0;
						if (q_cmd.opcode == msm_pkg::OP_STOP && q_vok) begin
							active_q[qvi] <= 1'b0;
						end
						if (q_cmd.opcode == msm_pkg::OP_VOLUME && q_vok) begin
							vol_q[qvi] <= q_cmd.volume;
						end
						if (q_cmd.opcode == msm_pkg::OP_STOP_ALL) begin
							for (int i = 0; i < VOICES; i++) begin
								active_q[i] <= 1'b0;
							end
						end
					end
				end
				msm_pkg::ST_DIV: begin
					if (div_done && vok) begin
						active_q[cvi] <= 1'b1;
						vol_q[cvi]    <= cmd_q.volume;
						base_q[cvi]   <= cmd_q.address;
						len_q[cvi]    <= cmd_q.length;
						ls_q[cvi]     <= cmd_q.loop_start;
						ll_q[cvi]     <= cmd_q.loop_length;
						pos_q[cvi]    <= '0;
						step_q[cvi]   <= div_quo;
					end
				end
				msm_pkg::ST_VOICE: begin
					if (active_q[idx_q]) begin
						pos_q[idx_q] <= next_pos;
						if (!looped && oneshot_end) begin
							active_q[idx_q] <= 1'b0;
						end
					end
					if (!(active_q[idx_q] && (looped || !oneshot_end)) && !last_voice) begin
						idx_q <= idx_q + VW'(1);
					end
				end
				msm_pkg::ST_ACC: begin
					sum_q <= sum_q + 16'(contrib);
					if (!last_voice) begin
						idx_q <= idx_q + VW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register: loaded at the end of a tick, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (state_q == msm_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
			out_q       <= {sum_q[10:0], 5'b00000};
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	// reserved opcodes, dropped by the block
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam int NV = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [2:0]  opc;
		logic [1:0]  voice;
		logic [15:0] address;
		logic [7:0]  sample_byte;
		logic [15:0] length;
		logic [15:0] loop_start;
		logic [15:0] loop_length;
		logic [15:0] frequency;
		logic [6:0]  volume;
	} mix_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [4:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	multichannel_sample_mixer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// mixer shadow state
	logic [7:0]  smem [65536];
	bit          smem_written [65536];
	bit          v_act [NV];
	logic [6:0]  v_vol [NV];
	logic [23:0] v_pos [NV];
	logic [23:0] v_step [NV];
	logic [15:0] v_base [NV];
	logic [15:0] v_len [NV];
	logic [15:0] v_ls [NV];
	logic [15:0] v_ll [NV];
	logic [15:0] rate;

	logic [15:0] mix_expect_q [$];
	int err_count;
	int cmd_count;
	int tick_count;
	int result_count;
	int src_idle_pct;
	int snk_idle_pct;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// second byte offset of a voice this tick; -1 when the one-shot voice ends
	function automatic int second_offset(int v, int p1);
		int endp;
		if (v_ll[v] != 0) begin
			endp = int'(v_ls[v]) + int'(v_ll[v]) - 1;
			return (p1 >= endp) ? int'(v_ls[v]) : p1 + 1;
		end
		if (p1 >= int'(v_len[v]) - 1)
			return -1;
		return p1 + 1;
	endfunction

	function automatic int sbyte_at(int v, int off);
		logic [15:0] a;
		a = 16'(v_base[v] + off);
		return int'($signed(smem[a]));
	endfunction

	// one voice's contribution; advances its position
	function automatic int voice_contrib(int v);
		int frac, p1, p2, s, b;
		logic [23:0] pos;
		pos = v_pos[v];
		frac = int'(pos[7:0]);
		p1 = int'(pos[23:8]);
		p2 = second_offset(v, p1);
		v_pos[v] = pos + v_step[v];
		if (p2 < 0) begin
			v_act[v] = 1'b0;
			return 0;
		end
		if (v_ll[v] != 0 && p1 >= int'(v_ls[v]) + int'(v_ll[v]) - 1)
			v_pos[v] = {v_ls[v], 8'h00};
		s = sbyte_at(v, p1) * (255 - frac) + sbyte_at(v, p2) * frac;
		b = s >>> 8;
		return (b * int'(v_vol[v])) / 64;
	endfunction

	task automatic apply_cmd(mix_cmd_t c);
		int sum;
		logic [23:0] num;
		case (c.opc)
			msm_pkg::OP_TICK: begin
				sum = 0;
				for (int v = 0; v < NV; v++)
					if (v_act[v])
						sum += voice_contrib(v);
				mix_expect_q.push_back(16'(sum << 5));
				tick_count++;
			end
			msm_pkg::OP_WRITE: begin
				smem[c.address] = c.sample_byte;
				smem_written[c.address] = 1'b1;
			end
			msm_pkg::OP_PLAY: begin
				v_act[c.voice] = 1'b1;
				v_vol[c.voice] = c.volume;
				v_base[c.voice] = c.address;
				v_len[c.voice] = c.length;
				v_ls[c.voice] = c.loop_start;
				v_ll[c.voice] = c.loop_length;
				v_pos[c.voice] = '0;
				num = {c.frequency, 8'h00};
				v_step[c.voice] = (rate == 0) ? 24'hFFFFFF : 24'(num / rate);
			end
			msm_pkg::OP_STOP: v_act[c.voice] = 1'b0;
			msm_pkg::OP_VOLUME: v_vol[c.voice] = c.volume;
			msm_pkg::OP_STOP_ALL: for (int v = 0; v < NV; v++) v_act[v] = 1'b0;
			default: ;
		endcase
		cmd_count++;
	endtask

	// drive one command beat and wait for its acceptance
	task automatic send_cmd(mix_cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= {c.voice, c.opc};
		s_axis_tdata <= {1'b0, c.volume, c.frequency, c.loop_length, c.loop_start,
			c.length, c.sample_byte, c.address};
		do @(posedge clk); while (!s_axis_tready);
		apply_cmd(c);
	endtask

	function automatic mix_cmd_t rand_fields();
		mix_cmd_t c;
		c.opc = msm_pkg::OP_TICK;
		c.voice = 2'($urandom_range(3));
		c.address = 16'($urandom);
		c.sample_byte = 8'($urandom);
		c.length = 16'($urandom);
		c.loop_start = 16'($urandom);
		c.loop_length = 16'($urandom);
		c.frequency = 16'($urandom);
		c.volume = 7'($urandom_range(127));
		return c;
	endfunction

	task automatic write_byte(logic [15:0] a, logic [7:0] d);
		mix_cmd_t c;
		c = rand_fields();
		c.opc = msm_pkg::OP_WRITE;
		c.address = a;
		c.sample_byte = d;
		send_cmd(c);
	endtask

	// store every byte the next tick will read that has not been written yet, then send the tick
	task automatic tick();
		mix_cmd_t c;
		int p1, p2;
		logic [15:0] a;
		for (int v = 0; v < NV; v++) begin
			if (!v_act[v])
				continue;
			p1 = int'(v_pos[v][23:8]);
			p2 = second_offset(v, p1);
			if (p2 < 0)
				continue;
			a = 16'(v_base[v] + p1);
			if (!smem_written[a]) write_byte(a, 8'($urandom));
			a = 16'(v_base[v] + p2);
			if (!smem_written[a]) write_byte(a, 8'($urandom));
		end
		c = rand_fields();
		c.opc = msm_pkg::OP_TICK;
		send_cmd(c);
	endtask

	task automatic play(logic [1:0] v, logic [15:0] base, logic [15:0] len,
		logic [15:0] ls, logic [15:0] ll, logic [15:0] freq, logic [6:0] vol);
		mix_cmd_t c;
		c = rand_fields();
		c.opc = msm_pkg::OP_PLAY;
		c.voice = v;
		c.address = base;
		c.length = len;
		c.loop_start = ls;
		c.loop_length = ll;
		c.frequency = freq;
		c.volume = vol;
		send_cmd(c);
	endtask

	task automatic simple_cmd(logic [2:0] opc, logic [1:0] v, logic [6:0] vol);
		mix_cmd_t c;
		c = rand_fields();
		c.opc = opc;
		c.voice = v;
		c.volume = vol;
		send_cmd(c);
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// wait for all results, then for the block to go quiet
	task automatic drain();
		release_bus();
		wait (mix_expect_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rate(logic [15:0] r);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		rate = r;
	endtask

	// directed: field extremes, every opcode, the named corner cases
	task automatic test_directed();
		write_byte(16'h0000, 8'h80);
		write_byte(16'hFFFF, 8'h7F);
		tick();
		play(2'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd22050, 7'd64);
		tick();
		play(2'd1, 16'hFFFF, 16'd4, 16'd0, 16'd0, 16'd11025, 7'd64);
		play(2'd2, 16'h8000, 16'hFFFF, 16'd2, 16'd3, 16'hFFFF, 7'd127);
		play(2'd3, 16'h1234, 16'd8, 16'hFFFF, 16'hFFFF, 16'd1000, 7'd0);
		tick();
		tick();
		simple_cmd(msm_pkg::OP_VOLUME, 2'd3, 7'd127);
		simple_cmd(OP_RSVD6, 2'd1, 7'd1);
		tick();
		simple_cmd(msm_pkg::OP_STOP, 2'd2, 7'd0);
		simple_cmd(OP_RSVD7, 2'd3, 7'd127);
		tick();
		tick();
		simple_cmd(msm_pkg::OP_STOP_ALL, 2'd0, 7'd0);
		tick();
	endtask

	// random traffic until n more input beats have been sent
	task automatic test_random(int n);
		mix_cmd_t c;
		int r;
		int stop_at;
		stop_at = cmd_count + n;
		while (cmd_count < stop_at) begin
			r = int'($urandom_range(99));
			if (r < 50)
				tick();
			else if (r < 62)
				write_byte(16'($urandom), 8'($urandom));
			else if (r < 74)
				play(2'($urandom_range(3)), 16'($urandom), 16'($urandom_range(1, 40)),
					16'($urandom_range(30)),
					($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(1, 24)),
					16'($urandom_range(2000, 65535)), 7'($urandom_range(0, 64)));
			else if (r < 78)
				play(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 7'($urandom_range(127)));
			else if (r < 85)
				simple_cmd(msm_pkg::OP_VOLUME, 2'($urandom_range(3)), 7'($urandom_range(127)));
			else if (r < 91)
				simple_cmd(msm_pkg::OP_STOP, 2'($urandom_range(3)), 7'($urandom));
			else if (r < 94)
				simple_cmd(msm_pkg::OP_STOP_ALL, 2'($urandom_range(3)), 7'($urandom));
			else if (r < 97) begin
				c = rand_fields();
				c.opc = ($urandom_range(1) == 0) ? OP_RSVD6 : OP_RSVD7;
				send_cmd(c);
			end else
				tick();
		end
	endtask

	// result checker and receiver stalls
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (mix_expect_q.size() == 0) begin
				$error("unexpected mixed_sample beat: %0d", $signed(m_axis_tdata));
				err_count++;
			end else begin
				if (m_axis_tdata !== mix_expect_q[0]) begin
					$error("mixed_sample: expected %0d, actual %0d",
						$signed(mix_expect_q[0]), $signed(m_axis_tdata));
					err_count++;
				end
				void'(mix_expect_q.pop_front());
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idle_cycles = 0;
		err_count = 0;
		cmd_count = 0;
		tick_count = 0;
		result_count = 0;
		rate = 16'd22050;
		for (int v = 0; v < NV; v++) begin
			v_act[v] = 0; v_vol[v] = 0; v_pos[v] = 0; v_step[v] = 0;
			v_base[v] = 0; v_len[v] = 0; v_ls[v] = 0; v_ll[v] = 0;
		end
		src_idle_pct = 15;
		snk_idle_pct = 80;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(380);
		set_rate(16'd65535);
		test_random(100);
		src_idle_pct = 80;
		snk_idle_pct = 15;
		set_rate(16'd1);
		test_random(200);
		set_rate(16'd0);
		test_random(100);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_rate(16'd8000);
		test_random(250);
		set_rate(16'd22050);
		test_random(200);
		drain();

		$display("covered %0d commands, %0d ticks, %0d results checked", cmd_count,
			tick_count, result_count);
		$display("rates 22050/65535/1/0/8000 under three handshake idle mixes");
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
